>>> rtl/mhpq_pkg.sv
// Package for the min-heap priority queue: sizes, codes, payload structs and
// the command/status structs between controller and datapath. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mhpq_pkg;

  localparam int MAX_ENTRIES = 1024;
  localparam int ADDR_W      = $clog2(MAX_ENTRIES);
  localparam int CNT_W       = 11;
  localparam int CAP_W       = 11;
  localparam int KEY_W       = 32;
  localparam int APB_AW      = 2;
  localparam int APB_DW      = 32;

  localparam logic [APB_AW-1:0] REG_CAPACITY = 2'd0;
  localparam logic [CAP_W-1:0]  CAP_RESET    = 11'd1024;

  typedef logic signed [KEY_W-1:0] key_t;

  localparam key_t KEY_MIN  = {1'b1, {(KEY_W-1){1'b0}}};
  localparam key_t KEY_ZERO = '0;

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_DELETE = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef struct packed {
    cmd_t command;
    key_t key_in;
  } in_item_t;

  typedef struct packed {
    key_t             key_out;
    status_t          status;
    logic [CNT_W-1:0] entry_total;
    key_t             current_min;
    logic             is_empty;
    logic             is_full;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // capture the accepted item
    logic set_full;   // insert refused
    logic set_empty;  // delete on an empty heap
    logic ins_start;  // grow count, start at the new leaf
    logic del_start;  // take the root, shrink count, read the last entry
    logic del_last;   // last entry becomes the key to sift down from the root
    logic up_read;    // read the parent
    logic up_move;    // parent moves down into the hole
    logic down_read;  // read both children
    logic down_move;  // smaller child moves up into the hole
    logic place;      // write the key into the hole
    logic respond;    // load the result register
  } ctl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_delete;
    logic full;
    logic empty;
    logic at_root;
    logic up_less;
    logic down_leaf;
    logic down_move;
  } sts_t;

endpackage

`default_nettype wire

>>> rtl/mhpq_regs.sv
// Configuration register file: the heap capacity register on an APB-style port.
// Depends on mhpq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mhpq_regs (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      psel,
  input  wire logic                      penable,
  input  wire logic                      pwrite,
  input  wire logic [mhpq_pkg::APB_AW-1:0] paddr,
  input  wire logic [mhpq_pkg::APB_DW-1:0] pwdata,
  output      logic [mhpq_pkg::APB_DW-1:0] prdata,
  output      logic                      pready,
  output      logic [mhpq_pkg::CAP_W-1:0]  capacity
);
  import mhpq_pkg::*;

  logic [CAP_W-1:0] cap_r;
  logic [CAP_W-1:0] cap_nxt;

  always_comb begin
    cap_nxt = cap_r;
    if (psel && penable && pwrite && (paddr == REG_CAPACITY)) begin
      cap_nxt = pwdata[CAP_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else begin
      cap_r <= cap_nxt;
    end
  end

  assign pready   = 1'b1;
  assign prdata   = (paddr == REG_CAPACITY) ? {{(APB_DW-CAP_W){1'b0}}, cap_r} : '0;
  assign capacity = cap_r;

endmodule

`default_nettype wire

>>> rtl/mhpq_ctrl.sv
// Controller state machine for the heap: sequences insert, sift-up, delete and
// sift-down by commands to the datapath. Depends on mhpq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mhpq_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           start,
  output      logic           busy,
  input  wire mhpq_pkg::sts_t sts,
  output      mhpq_pkg::ctl_t ctl
);
  import mhpq_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE     = 8'b0000_0001,
    S_DECIDE   = 8'b0000_0010,
    S_UP_CHK   = 8'b0000_0100,
    S_UP_CMP   = 8'b0000_1000,
    S_DEL_WAIT = 8'b0001_0000,
    S_SD_RD    = 8'b0010_0000,
    S_SD_CMP   = 8'b0100_0000,
    S_RESP     = 8'b1000_0000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    state_nxt = state_r;
    ctl       = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          ctl.load  = 1'b1;
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (!sts.is_delete) begin
          if (sts.full) begin
            ctl.set_full = 1'b1;
            state_nxt    = S_RESP;
          end else begin
            ctl.ins_start = 1'b1;
            state_nxt     = S_UP_CHK;
          end
        end else if (sts.empty) begin
          ctl.set_empty = 1'b1;
          state_nxt     = S_RESP;
        end else begin
          ctl.del_start = 1'b1;
          state_nxt     = S_DEL_WAIT;
        end
      end
      S_UP_CHK: begin
        if (sts.at_root) begin
          ctl.place = 1'b1;
          state_nxt = S_RESP;
        end else begin
          ctl.up_read = 1'b1;
          state_nxt   = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        if (sts.up_less) begin
          ctl.up_move = 1'b1;
          state_nxt   = S_UP_CHK;
        end else begin
          ctl.place = 1'b1;
          state_nxt = S_RESP;
        end
      end
      S_DEL_WAIT: begin
        ctl.del_last = 1'b1;
        state_nxt    = sts.empty ? S_RESP : S_SD_RD;
      end
      S_SD_RD: begin
        if (sts.down_leaf) begin
          ctl.place = 1'b1;
          state_nxt = S_RESP;
        end else begin
          ctl.down_read = 1'b1;
          state_nxt     = S_SD_CMP;
        end
      end
      S_SD_CMP: begin
        if (sts.down_move) begin
          ctl.down_move = 1'b1;
          state_nxt     = S_SD_RD;
        end else begin
          ctl.place = 1'b1;
          state_nxt = S_RESP;
        end
      end
      S_RESP: begin
        ctl.respond = 1'b1;
        state_nxt   = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule

`default_nettype wire

>>> rtl/mhpq_dp.sv
// Datapath of the heap: key store with one write and two registered read
// ports, count, hole position, cached root and result register. Depends on mhpq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mhpq_dp (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire mhpq_pkg::in_item_t       in_item,
  input  wire mhpq_pkg::ctl_t           ctl,
  input  wire logic [mhpq_pkg::CAP_W-1:0] capacity,
  output      mhpq_pkg::sts_t           sts,
  output      logic                     out_valid,
  output      mhpq_pkg::out_item_t      out_item
);
  import mhpq_pkg::*;

  key_t heap_mem [MAX_ENTRIES];

  cmd_t             cmd_r, cmd_nxt;
  key_t             key_r, key_nxt;
  key_t             key_out_r, key_out_nxt;
  status_t          status_r, status_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [ADDR_W-1:0] pos_r, pos_nxt;
  logic             right_ok_r, right_ok_nxt;
  key_t             root_r, root_nxt;
  key_t             rd0_r, rd1_r;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_r, out_nxt;

  logic              wen;
  logic [ADDR_W-1:0] waddr;
  key_t              wdata;
  logic [ADDR_W-1:0] raddr0;
  logic [ADDR_W-1:0] raddr1;

  logic [CNT_W-1:0]  cap_eff;
  logic [ADDR_W-1:0] parent_idx;
  logic [ADDR_W:0]   left_idx;
  logic [ADDR_W+1:0] right_idx;
  logic              take_right;
  key_t              sel_key;
  logic [ADDR_W-1:0] sel_idx;
  logic [CNT_W-1:0]  cnt_dec;

  assign cap_eff    = (capacity > CNT_W'(MAX_ENTRIES)) ? CNT_W'(MAX_ENTRIES) : capacity;
  assign parent_idx = (pos_r - ADDR_W'(1)) >> 1;
  assign left_idx   = {pos_r, 1'b1};
  assign right_idx  = {1'b0, left_idx} + (ADDR_W+2)'(1);
  assign take_right = right_ok_r && (rd1_r < rd0_r);
  assign sel_key    = take_right ? rd1_r : rd0_r;
  assign sel_idx    = take_right ? right_idx[ADDR_W-1:0] : left_idx[ADDR_W-1:0];
  assign cnt_dec    = cnt_r - CNT_W'(1);

  always_comb begin
    sts.is_delete = (cmd_r == CMD_DELETE);
    sts.full      = (cnt_r >= cap_eff);
    sts.empty     = (cnt_r == '0);
    sts.at_root   = (pos_r == '0);
    sts.up_less   = (key_r < rd0_r);
    sts.down_leaf = ({1'b0, left_idx} >= {{(ADDR_W+2-CNT_W){1'b0}}, cnt_r});
    sts.down_move = (sel_key < key_r);
  end

  always_comb begin
    cmd_nxt       = cmd_r;
    key_nxt       = key_r;
    key_out_nxt   = key_out_r;
    status_nxt    = status_r;
    cnt_nxt       = cnt_r;
    pos_nxt       = pos_r;
    right_ok_nxt  = right_ok_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    wen           = 1'b0;
    waddr         = pos_r;
    wdata         = key_r;
    raddr0        = '0;
    raddr1        = '0;

    if (ctl.load) begin
      cmd_nxt     = in_item.command;
      key_nxt     = in_item.key_in;
      key_out_nxt = KEY_ZERO;
      status_nxt  = ST_OK;
    end
    if (ctl.set_full) begin
      status_nxt = ST_FULL;
    end
    if (ctl.set_empty) begin
      status_nxt  = ST_EMPTY;
      key_out_nxt = KEY_MIN;
    end
    if (ctl.ins_start) begin
      pos_nxt = cnt_r[ADDR_W-1:0];
      cnt_nxt = cnt_r + CNT_W'(1);
    end
    if (ctl.del_start) begin
      key_out_nxt = root_r;
      cnt_nxt     = cnt_dec;
      raddr0      = cnt_dec[ADDR_W-1:0];
    end
    if (ctl.del_last) begin
      key_nxt = rd0_r;
      pos_nxt = '0;
    end
    if (ctl.up_read) begin
      raddr0 = parent_idx;
    end
    if (ctl.up_move) begin
      wen     = 1'b1;
      wdata   = rd0_r;
      pos_nxt = parent_idx;
    end
    if (ctl.down_read) begin
      raddr0       = left_idx[ADDR_W-1:0];
      raddr1       = right_idx[ADDR_W-1:0];
      right_ok_nxt = (right_idx < {{(ADDR_W+2-CNT_W){1'b0}}, cnt_r});
    end
    if (ctl.down_move) begin
      wen     = 1'b1;
      wdata   = sel_key;
      pos_nxt = sel_idx;
    end
    if (ctl.place) begin
      wen   = 1'b1;
      wdata = key_r;
    end
    if (ctl.respond) begin
      out_valid_nxt       = 1'b1;
      out_nxt.key_out     = key_out_r;
      out_nxt.status      = status_r;
      out_nxt.entry_total = cnt_r;
      out_nxt.current_min = (cnt_r == '0) ? KEY_MIN : root_r;
      out_nxt.is_empty    = (cnt_r == '0);
      out_nxt.is_full     = (cnt_r >= cap_eff);
    end
  end

  // The root is cached so that the minimum is available without a read.
  assign root_nxt = (wen && (waddr == '0)) ? wdata : root_r;

  always_ff @(posedge clk) begin
    if (wen) begin
      heap_mem[waddr] <= wdata;
    end
    rd0_r <= heap_mem[raddr0];
    rd1_r <= heap_mem[raddr1];
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    key_r      <= key_nxt;
    key_out_r  <= key_out_nxt;
    status_r   <= status_nxt;
    pos_r      <= pos_nxt;
    right_ok_r <= right_ok_nxt;
    root_r     <= root_nxt;
    out_r      <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

`default_nettype wire

>>> rtl/min_heap_priority_queue.sv
// Top level of the binary min-heap priority queue of signed 32-bit keys.
// Depends on mhpq_pkg, mhpq_regs, mhpq_ctrl and mhpq_dp.
//
// A command is transferred at a rising edge where start is high and busy is
// low. An insert places in_item.key_in at the end of the heap and sifts it up
// while it is strictly smaller than its parent; it is refused with the full
// status when the count has reached the smaller of heap_capacity and the store
// depth. A delete returns the root and sifts the last entry down from the root
// toward the smaller child (the left one on a tie); on an empty heap it
// returns the most negative key with the empty status. Every command produces
// exactly one result, shown on out_item for a single cycle with out_valid
// high; the receiver cannot stall, so it must take each result in that cycle.
// Busy drops in the same cycle that the result is shown, so the next command
// may be transferred while the previous result is on the ports.
//
// Sequencing: one command is worked on at a time. Each heap level visited
// takes a read of the store (for a delete, both children at once through its
// two read ports) and then a compare and a write. A refused insert, a delete
// on an empty heap and a delete that leaves the heap empty skip the sift.
// The capacity register sits at byte address 0 of the APB-style port; writes
// take effect immediately and should only be made while the block is idle.
// The key store has no reset; only entries below the count are ever used.
`timescale 1ns / 1ps
`default_nettype none

module min_heap_priority_queue (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  output      logic                        busy,
  input  wire mhpq_pkg::in_item_t          in_item,
  output      logic                        out_valid,
  output      mhpq_pkg::out_item_t         out_item,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [mhpq_pkg::APB_AW-1:0] paddr,
  input  wire logic [mhpq_pkg::APB_DW-1:0] pwdata,
  output      logic [mhpq_pkg::APB_DW-1:0] prdata,
  output      logic                        pready
);
  import mhpq_pkg::*;

  logic [CAP_W-1:0] capacity;
  ctl_t             ctl;
  sts_t             sts;

  // Configuration: the capacity register.
  mhpq_regs u_regs (
    .clk      (clk),
    .rst_n    (rst_n),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .capacity (capacity)
  );

  // Sequencing of each command; it owns the busy flag.
  mhpq_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .ctl   (ctl)
  );

  // Key store, count, hole position and the result register.
  mhpq_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .ctl       (ctl),
    .capacity  (capacity),
    .sts       (sts),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

`default_nettype wire

>>> verif/testbench.sv
// Self-checking testbench for the min_heap_priority_queue block.
// Depends on mhpq_pkg and the RTL of the block; it reads nothing else.
`timescale 1ns / 1ps

module testbench;
  import mhpq_pkg::*;

  // Allowed clock cycles for the whole run: several times the slowest correct
  // run of about 1250 commands with their busy time and the gaps between them.
  localparam int CYCLE_LIMIT = 400000;
  // Cycles to wait after the last expected result for any stray result.
  localparam int TAIL_CYCLES = 40;

  // Mirror of the heap: it computes the result of each accepted command and
  // holds the results not yet seen on the output.
  class heap_scoreboard;
    key_t                keys [MAX_ENTRIES];
    int                  count;
    logic [CAP_W-1:0]    capacity;
    out_item_t           pending [$];
    int                  errors;

    function new();
      foreach (keys[i]) keys[i] = KEY_ZERO;
      count    = 0;
      capacity = CAP_RESET;
      errors   = 0;
    endfunction

    function void set_capacity(logic [CAP_W-1:0] value);
      capacity = value;
    endfunction

    // Applies one accepted command to the mirror and queues its result.
    function void note_input(in_item_t item);
      out_item_t res;
      int        cap;
      int        pos;
      int        parent;
      int        child;
      key_t      moving;
      cap = (capacity < MAX_ENTRIES) ? int'(capacity) : MAX_ENTRIES;
      res = '0;
      res.key_out = KEY_ZERO;
      res.status  = ST_OK;
      if (item.command == CMD_INSERT) begin
        if (count >= cap) begin
          res.status = ST_FULL;
        end else begin
          // The new key climbs while it is strictly smaller than its parent.
          count++;
          pos    = count - 1;
          moving = item.key_in;
          while (pos > 0) begin
            parent = (pos - 1) / 2;
            if (!(moving < keys[parent])) break;
            keys[pos] = keys[parent];
            pos = parent;
          end
          keys[pos] = moving;
        end
      end else begin
        if (count == 0) begin
          res.key_out = KEY_MIN;
          res.status  = ST_EMPTY;
        end else begin
          res.key_out = keys[0];
          count--;
          moving = keys[count];
          if (count > 0) begin
            // The last entry descends toward the smaller child; on a tie the
            // left child is taken, and an equal child stops it.
            pos = 0;
            forever begin
              child = 2 * pos + 1;
              if (child >= count) break;
              if (child + 1 < count && keys[child + 1] < keys[child]) child++;
              if (!(keys[child] < moving)) break;
              keys[pos] = keys[child];
              pos = child;
            end
            keys[pos] = moving;
          end
        end
      end
      res.entry_total = CNT_W'(count);
      res.current_min = (count > 0) ? keys[0] : KEY_MIN;
      res.is_empty    = (count == 0);
      res.is_full     = (count >= cap);
      pending.push_back(res);
    endfunction

    // Compares one result from the block with the oldest expected one.
    function void check_result(out_item_t got);
      out_item_t want;
      if (pending.size() == 0) begin
        $error("unexpected result: key_out %0d status %0d", got.key_out, got.status);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.key_out !== want.key_out) begin
        $error("key_out: expected %0d, actual %0d", want.key_out, got.key_out);
        errors++;
      end
      if (got.status !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, got.status);
        errors++;
      end
      if (got.entry_total !== want.entry_total) begin
        $error("entry_total: expected %0d, actual %0d", want.entry_total, got.entry_total);
        errors++;
      end
      if (got.current_min !== want.current_min) begin
        $error("current_min: expected %0d, actual %0d", want.current_min, got.current_min);
        errors++;
      end
      if (got.is_empty !== want.is_empty) begin
        $error("is_empty: expected %0b, actual %0b", want.is_empty, got.is_empty);
        errors++;
      end
      if (got.is_full !== want.is_full) begin
        $error("is_full: expected %0b, actual %0b", want.is_full, got.is_full);
        errors++;
      end
    endfunction
  endclass

  logic                clk;
  logic                rst_n;
  logic                start;
  logic                busy;
  in_item_t            in_item;
  logic                out_valid;
  out_item_t           out_item;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [APB_AW-1:0]   paddr;
  logic [APB_DW-1:0]   pwdata;
  logic [APB_DW-1:0]   prdata;
  logic                pready;

  heap_scoreboard      sb;
  int                  cycles;
  // When clear, commands follow each other with no gaps.
  bit                  gaps_on;

  min_heap_priority_queue dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Every result is valid for one cycle only and cannot be held off, so it
  // is checked at the edge that ends that cycle.
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1) sb.check_result(out_item);
  end

  // Mix of keys: extremes, a narrow band that gives many equal keys, and
  // full-range values so that every key bit toggles.
  function automatic key_t pick_key();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 2) begin
      case ($urandom_range(0, 5))
        0: return KEY_MIN;
        1: return KEY_MIN + 1;
        2: return -1;
        3: return KEY_ZERO;
        4: return 1;
        default: return ~KEY_MIN;
      endcase
    end else if (sel < 6) begin
      return key_t'($signed($urandom_range(0, 16)) - 8);
    end
    return key_t'($urandom());
  endfunction

  // Presents one command and holds it until it is transferred; the mirror
  // is updated at the edge of the transfer.
  task automatic issue(cmd_t cmd, key_t key);
    in_item_t item;
    item.command = cmd;
    item.key_in  = key;
    in_item <= item;
    start   <= 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
    sb.note_input(item);
  endtask

  // Sometimes drops start for a random burst between commands.
  task automatic maybe_pause();
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  task automatic directed(cmd_t cmd, key_t key);
    maybe_pause();
    issue(cmd, key);
  endtask

  // Stops issuing and waits until every expected result has been seen.
  task automatic drain();
    start <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  // Writes the capacity register, then reads it back. The bits above the
  // register width carry random data that the block must drop.
  task automatic program_capacity(logic [CAP_W-1:0] value);
    logic [APB_DW-1:0] word;
    word = $urandom();
    word[CAP_W-1:0] = value;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= REG_CAPACITY;
    pwdata  <= word;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    sb.set_capacity(value);
    // Straight into the read setup; psel stays high.
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    if (prdata[CAP_W-1:0] !== value) begin
      $error("heap_capacity: expected %0d, actual %0d", value, prdata[CAP_W-1:0]);
      sb.errors++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // A run of random commands with the given share of inserts, in percent.
  task automatic random_run(int n, int insert_pct, bit allow_gaps);
    cmd_t cmd;
    for (int i = 0; i < n; i++) begin
      if (i % 40 == 0) gaps_on = allow_gaps && ($urandom_range(0, 2) != 0);
      cmd = ($urandom_range(0, 99) < insert_pct) ? CMD_INSERT : CMD_DELETE;
      maybe_pause();
      issue(cmd, pick_key());
    end
  endtask

  task automatic random_phase(logic [CAP_W-1:0] cap, int n, int insert_pct);
    drain();
    program_capacity(cap);
    random_run(n, insert_pct, 1'b1);
  endtask

  initial begin
    int filler;
    sb      = new();
    cycles  = 0;
    gaps_on = 1'b1;
    rst_n   <= 1'b0;
    start   <= 1'b0;
    in_item <= '0;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part at the reset capacity: delete from the empty heap, key
    // extremes, equal keys and deletes that pull them back out in order.
    directed(CMD_DELETE, pick_key());
    directed(CMD_INSERT, ~KEY_MIN);
    directed(CMD_INSERT, KEY_MIN);
    directed(CMD_INSERT, KEY_ZERO);
    directed(CMD_INSERT, -1);
    directed(CMD_INSERT, 5);
    directed(CMD_INSERT, 5);
    directed(CMD_INSERT, 5);
    directed(CMD_INSERT, 3);
    repeat (4) directed(CMD_DELETE, pick_key());

    // Capacity lowered below the count: inserts are refused until deletes bring the count below it, deletes work.
    drain();
    program_capacity(11'd2);
    directed(CMD_INSERT, 7);
    directed(CMD_INSERT, 1);
    repeat (3) directed(CMD_DELETE, pick_key());
    directed(CMD_INSERT, 9);
    directed(CMD_INSERT, 2);
    repeat (3) directed(CMD_DELETE, pick_key());

    // Zero capacity refuses every insert.
    drain();
    program_capacity(11'd0);
    directed(CMD_INSERT, 4);
    directed(CMD_DELETE, pick_key());

    // Random phases with small capacities, where full and empty come often.
    random_phase(11'd8, 30, 55);
    random_phase(11'd1, 15, 50);
    random_phase(11'd0, 10, 40);
    random_phase(11'd40, 40, 65);
    random_phase(11'd10, 15, 35);

    // Capacity above the store depth: the heap fills to the full depth of
    // the store, which exercises the deepest sift paths in both directions.
    drain();
    program_capacity(11'h7FF);
    filler = 0;
    while (sb.count < MAX_ENTRIES && filler < 4 * MAX_ENTRIES) begin
      if (filler % 40 == 0) gaps_on = ($urandom_range(0, 2) != 0);
      maybe_pause();
      issue(($urandom_range(0, 99) < 99) ? CMD_INSERT : CMD_DELETE, pick_key());
      filler++;
    end
    // The closing stretch runs back to back, with no gaps at all.
    random_run(80, 45, 1'b0);

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

>>> min_heap_priority_queue.f
rtl/mhpq_pkg.sv
rtl/mhpq_regs.sv
rtl/mhpq_ctrl.sv
rtl/mhpq_dp.sv
rtl/min_heap_priority_queue.sv
verif/testbench.sv
